// ===== rtl/brle_pkg.sv =====
package brle_pkg;

    // Longest run, literal or repeat, that one header byte describes.
    localparam int MAX_RUN    = 128;
    localparam int RUN_CNT_W  = $clog2(MAX_RUN + 1);
    localparam int LIT_ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    // Command queue between the classifier and the emitter.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Bytes in one packed output word.
    localparam int WORD_BYTES = 8;
    localparam int FILL_W     = 4;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_LCLOSE,
        CMD_REP,
        CMD_END
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic [7:0] hdr;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LIT,
        MODE_REP
    } run_mode_t;

    typedef enum logic [1:0] {
        F_RUN,
        F_DRAIN_A,
        F_DRAIN_B,
        F_CLOSE
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RHDR,
        B_RVAL,
        B_LHDR,
        B_LDATA,
        B_END
    } back_state_t;

endpackage

// ===== rtl/brle_front.sv =====
module brle_front
    import brle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] in_byte,
    input  logic      is_last,
    input  logic      q_space2,
    output cmd_push_t push0,
    output cmd_push_t push1
);

    front_state_t         state_reg, state_next;
    run_mode_t            mode_reg, mode_next;
    logic [1:0]           afill_reg, afill_next;
    logic [7:0]           a0_reg, a0_next;
    logic [7:0]           a1_reg, a1_next;
    logic [7:0]           rep_val_reg, rep_val_next;
    logic [RUN_CNT_W-1:0] rep_len_reg, rep_len_next;
    logic [RUN_CNT_W-1:0] lit_cnt_reg, lit_cnt_next;

    logic       take_en;
    logic [7:0] tx, tx1, tx2;
    logic       th1, th2;
    logic       fall;

    function automatic cmd_push_t mk_cmd(cmd_op_t op, logic [7:0] data, logic [7:0] hdr);
        cmd_push_t p;
        p.valid    = 1'b1;
        p.cmd.op   = op;
        p.cmd.data = data;
        p.cmd.hdr  = hdr;
        return p;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        afill_next   = afill_reg;
        a0_next      = a0_reg;
        a1_next      = a1_reg;
        rep_val_next = rep_val_reg;
        rep_len_next = rep_len_reg;
        lit_cnt_next = lit_cnt_reg;
        push0        = '0;
        push1        = '0;
        in_ready     = (state_reg == F_RUN) && q_space2;
        take_en      = 1'b0;
        tx           = a0_reg;
        th1          = 1'b0;
        tx1          = a1_reg;
        th2          = 1'b0;
        tx2          = in_byte;
        fall         = 1'b0;

        unique case (state_reg)
            F_RUN:
            begin
                if (in_valid && in_ready)
                begin
                    if (afill_reg == 2'd2)
                    begin
                        take_en = 1'b1;
                        th1     = 1'b1;
                        th2     = 1'b1;
                        a0_next = a1_reg;
                        a1_next = in_byte;
                    end
                    else if (afill_reg == 2'd1)
                    begin
                        a1_next    = in_byte;
                        afill_next = 2'd2;
                    end
                    else
                    begin
                        a0_next    = in_byte;
                        afill_next = 2'd1;
                    end
                    if (is_last)
                    begin
                        state_next = (afill_reg != 2'd0) ? F_DRAIN_A : F_DRAIN_B;
                    end
                end
            end
            F_DRAIN_A:
            begin
                if (q_space2)
                begin
                    take_en    = 1'b1;
                    th1        = 1'b1;
                    state_next = F_DRAIN_B;
                end
            end
            F_DRAIN_B:
            begin
                if (q_space2)
                begin
                    take_en    = 1'b1;
                    tx         = (afill_reg == 2'd2) ? a1_reg : a0_reg;
                    state_next = F_CLOSE;
                end
            end
            F_CLOSE:
            begin
                if (q_space2)
                begin
                    if (mode_reg == MODE_LIT)
                    begin
                        push0 = mk_cmd(CMD_LCLOSE, 8'd0, 8'd0);
                    end
                    else if (mode_reg == MODE_REP)
                    begin
                        push0 = mk_cmd(CMD_REP, rep_val_reg, 8'd1 - 8'(rep_len_reg));
                    end
                    push1        = mk_cmd(CMD_END, 8'd0, 8'd0);
                    mode_next    = MODE_IDLE;
                    afill_next   = 2'd0;
                    rep_len_next = '0;
                    lit_cnt_next = '0;
                    state_next   = F_RUN;
                end
            end
            default:
            begin
                state_next = F_RUN;
            end
        endcase

        // Decide one byte against the bytes that follow it.
        if (take_en)
        begin
            case (mode_reg)
                MODE_REP:
                begin
                    if (tx == rep_val_reg)
                    begin
                        rep_len_next = rep_len_reg + 1'b1;
                        if (rep_len_next == RUN_CNT_W'(MAX_RUN))
                        begin
                            push0        = mk_cmd(CMD_REP, rep_val_reg,
                                                  8'd1 - 8'(rep_len_next));
                            mode_next    = MODE_IDLE;
                            rep_len_next = '0;
                        end
                    end
                    else
                    begin
                        push0 = mk_cmd(CMD_REP, rep_val_reg, 8'd1 - 8'(rep_len_reg));
                        fall  = 1'b1;
                    end
                end
                MODE_LIT:
                begin
                    if (!th2 || tx != tx1 || tx != tx2)
                    begin
                        lit_cnt_next = lit_cnt_reg + 1'b1;
                        push0        = mk_cmd(CMD_LIT, tx, 8'd0);
                        if (lit_cnt_next == RUN_CNT_W'(MAX_RUN))
                        begin
                            push1        = mk_cmd(CMD_LCLOSE, 8'd0, 8'd0);
                            mode_next    = MODE_IDLE;
                            lit_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        push0 = mk_cmd(CMD_LCLOSE, 8'd0, 8'd0);
                        fall  = 1'b1;
                    end
                end
                default:
                begin
                    fall = 1'b1;
                end
            endcase

            if (fall)
            begin
                rep_len_next = '0;
                lit_cnt_next = '0;
                if (th1 && tx == tx1)
                begin
                    mode_next    = MODE_REP;
                    rep_val_next = tx;
                    rep_len_next = RUN_CNT_W'(1);
                end
                else
                begin
                    mode_next    = MODE_LIT;
                    lit_cnt_next = RUN_CNT_W'(1);
                    push1        = mk_cmd(CMD_LIT, tx, 8'd0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_RUN;
            mode_reg    <= MODE_IDLE;
            afill_reg   <= 2'd0;
            rep_len_reg <= '0;
            lit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            afill_reg   <= afill_next;
            rep_len_reg <= rep_len_next;
            lit_cnt_reg <= lit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg      <= a0_next;
        a1_reg      <= a1_next;
        rep_val_reg <= rep_val_next;
    end

    // An open repeat run always holds at least one byte and never a full run.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_REP |-> rep_len_reg != '0 && rep_len_reg < RUN_CNT_W'(MAX_RUN))
        else $error("open repeat run has a bad length");

    // An open literal run is never empty and is flushed before it overflows the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_LIT |-> lit_cnt_reg != '0 && lit_cnt_reg < RUN_CNT_W'(MAX_RUN))
        else $error("open literal run has a bad length");

endmodule

// ===== rtl/brle_cmd_fifo.sv =====
module brle_cmd_fifo
    import brle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_push_t push0,
    input  cmd_push_t push1,
    output logic      space2,
    output logic      pop_valid,
    output cmd_t      pop_cmd,
    input  logic      pop_ready
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CMDQ_PTR_W-1:0] wa1;
    logic [1:0]            n_push;
    logic                  pop;

    function automatic logic [CMDQ_PTR_W-1:0] inc_ptr(logic [CMDQ_PTR_W-1:0] p);
        return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        n_push      = 2'(push0.valid) + 2'(push1.valid);
        pop         = pop_valid && pop_ready;
        wa1         = push0.valid ? inc_ptr(wr_ptr_reg) : wr_ptr_reg;
        wr_ptr_next = push1.valid ? inc_ptr(wa1) : wa1;
        rd_ptr_next = pop ? inc_ptr(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CMDQ_CNT_W'(n_push) - CMDQ_CNT_W'(pop);
    end

    assign space2    = cnt_reg <= CMDQ_CNT_W'(CMDQ_DEPTH - 2);
    assign pop_valid = cnt_reg != '0;
    assign pop_cmd   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0.valid)
        begin
            q_reg[wr_ptr_reg] <= push0.cmd;
        end
        if (push1.valid)
        begin
            q_reg[wa1] <= push1.cmd;
        end
    end

    // The classifier only pushes when there is room, so the queue never overflows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push0.valid || push1.valid) |-> int'(cnt_reg) + int'(n_push) <= CMDQ_DEPTH)
        else $error("command queue overflow");

endmodule

// ===== rtl/brle_back.sv =====
module brle_back
    import brle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       out_word,
    output logic [FILL_W-1:0] out_count,
    output logic              out_last
);

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [RUN_CNT_W-1:0] wcnt_reg, wcnt_next;
    logic [RUN_CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [63:0]          pack_word_reg, pack_word_next;
    logic [FILL_W-1:0]    pack_fill_reg, pack_fill_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_word_reg, out_word_next;
    logic [FILL_W-1:0]    out_count_reg, out_count_next;
    logic                 out_last_reg, out_last_next;

    logic [7:0] lit_mem [MAX_RUN];
    logic [7:0] rd_data_reg;
    logic       mem_we;

    logic       out_free;
    logic       byte_valid;
    logic [7:0] byte_val;
    logic       byte_take;
    logic       pack_full;

    assign out_free  = !out_valid_reg || out_ready;
    assign pack_full = pack_fill_reg == FILL_W'(WORD_BYTES);
    assign q_ready   = state_reg == B_IDLE;

    always_comb
    begin
        byte_valid = 1'b0;
        byte_val   = 8'd0;
        unique case (state_reg)
            B_RHDR:
            begin
                byte_valid = 1'b1;
                byte_val   = cmd_reg.hdr;
            end
            B_RVAL:
            begin
                byte_valid = 1'b1;
                byte_val   = cmd_reg.data;
            end
            B_LHDR:
            begin
                byte_valid = 1'b1;
                byte_val   = 8'(wcnt_reg) - 8'd1;
            end
            B_LDATA:
            begin
                byte_valid = 1'b1;
                byte_val   = rd_data_reg;
            end
            default:
            begin
                byte_valid = 1'b0;
            end
        endcase
        byte_take = byte_valid && (!pack_full || out_free);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        wcnt_next      = wcnt_reg;
        rd_idx_next    = rd_idx_reg;
        mem_we         = 1'b0;
        pack_word_next = pack_word_reg;
        pack_fill_next = pack_fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    unique case (q_cmd.op)
                        CMD_LIT:
                        begin
                            mem_we    = 1'b1;
                            wcnt_next = wcnt_reg + 1'b1;
                        end
                        CMD_LCLOSE:
                        begin
                            rd_idx_next = '0;
                            state_next  = B_LHDR;
                        end
                        CMD_REP:
                        begin
                            state_next = B_RHDR;
                        end
                        CMD_END:
                        begin
                            state_next = B_END;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_RHDR:
            begin
                if (byte_take)
                begin
                    state_next = B_RVAL;
                end
            end
            B_RVAL:
            begin
                if (byte_take)
                begin
                    state_next = B_IDLE;
                end
            end
            B_LHDR:
            begin
                if (byte_take)
                begin
                    state_next = B_LDATA;
                end
            end
            B_LDATA:
            begin
                if (byte_take)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    if (rd_idx_next == wcnt_reg)
                    begin
                        wcnt_next  = '0;
                        state_next = B_IDLE;
                    end
                end
            end
            B_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = pack_word_reg;
                    out_count_next = pack_fill_reg;
                    out_last_next  = 1'b1;
                    pack_word_next = '0;
                    pack_fill_next = '0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // A full word waits for the next byte or the end of the stream.
        if (byte_take)
        begin
            if (pack_full)
            begin
                out_valid_next = 1'b1;
                out_word_next  = pack_word_reg;
                out_count_next = pack_fill_reg;
                out_last_next  = 1'b0;
                pack_word_next = {56'd0, byte_val};
                pack_fill_next = FILL_W'(1);
            end
            else
            begin
                pack_word_next[{pack_fill_reg[2:0], 3'b000} +: 8] = byte_val;
                pack_fill_next = pack_fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            wcnt_reg      <= '0;
            rd_idx_reg    <= '0;
            pack_word_reg <= '0;
            pack_fill_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wcnt_reg      <= wcnt_next;
            rd_idx_reg    <= rd_idx_next;
            pack_word_reg <= pack_word_next;
            pack_fill_reg <= pack_fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        out_word_reg  <= out_word_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lit_mem[wcnt_reg[LIT_ADDR_W-1:0]] <= q_cmd.data;
        end
        rd_data_reg <= lit_mem[rd_idx_next[LIT_ADDR_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

    // Every word sent carries one to eight bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg != '0 && out_count_reg <= FILL_W'(WORD_BYTES))
        else $error("output word with a bad byte count");

    // The literal readout never walks past the bytes that were stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_LDATA |-> rd_idx_reg < wcnt_reg)
        else $error("literal readout beyond stored bytes");

    // The packing word never holds more than a full word.
    assert property (@(posedge clk) disable iff (!rst_n)
        pack_fill_reg <= FILL_W'(WORD_BYTES))
        else $error("packing word overfilled");

endmodule

// ===== rtl/byte_run_length_encoder.sv =====
// Channel  Handshake              Payload                          Direction
// input    in_valid / in_ready    in_byte[7:0], is_last            into the block
// output   out_valid / out_ready  out_word[63:0], out_count[3:0],  out of the block
//                                 out_last
//
// A raw byte is taken whenever the classifier is not closing a stream and the command
// queue has room for two commands.
// The emitter sets the sustained rate: it stores each queued literal byte, reads each
// literal byte back, fetches a literal run's close command and sends the header, and
// fetches each repeat run's command and sends its two bytes.
// At the end of a stream the classifier drains the look-ahead in F_DRAIN_A and F_DRAIN_B
// and closes the run in F_CLOSE; a stream of a single byte skips F_DRAIN_A.
// Reset clears all control state; the literal store needs no clearing pass.
// A stalled output only stops the packer once it holds a full word behind a busy register.

module byte_run_length_encoder
    import brle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_word,
    output logic [3:0]  out_count,
    output logic        out_last
);

    // The classifier keeps a two-byte look-ahead and the run state. For every byte it
    // decides whether the byte extends a repeat run, joins a literal run or starts a new
    // run, and it issues up to two commands per decision: close a run and store a literal
    // byte, in either order. Literal bytes go to the emitter, owner of the literal store.
    cmd_push_t push0;
    cmd_push_t push1;
    logic      q_space2;
    logic      q_valid;
    cmd_t      q_cmd;
    logic      q_ready;

    brle_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .is_last  (is_last),
        .q_space2 (q_space2),
        .push0    (push0),
        .push1    (push1)
    );

    // The short command queue lets the classifier run ahead while the emitter reads
    // out a long literal run or waits on the output, and lets the emitter keep
    // draining while no new bytes arrive.
    brle_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .space2    (q_space2),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd),
        .pop_ready (q_ready)
    );

    // The emitter writes literal bytes into its store, turns close commands into header
    // and data bytes, packs them eight to a word with the first byte in the low bits,
    // and holds each finished word in an output register until its transfer completes.
    brle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_ready   (q_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .out_count (out_count),
        .out_last  (out_last)
    );

endmodule

// ===== bench/brle_checker.sv =====
`timescale 1ns / 100ps

module brle_checker
    import brle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] out_word,
    input  logic [3:0]  out_count,
    input  logic        out_last,
    output int          mismatches,
    output int          words_owed
);

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
    } coded_word_t;

    // Encoded words still owed by the block, oldest first.
    coded_word_t owed_words[$];

    // Shadow copy of the encoder state.
    logic [7:0]  lit_bytes [MAX_RUN];
    int          lit_len;
    logic [7:0]  window [2];
    int          window_len;
    logic [7:0]  rep_byte;
    int          rep_len;
    run_mode_t   mode;
    logic [63:0] acc_word;
    int          acc_fill;

    function automatic void ship_word(logic last);
        coded_word_t w;
        w.word  = acc_word;
        w.count = 4'(acc_fill);
        w.last  = last;
        owed_words.push_back(w);
        acc_word = '0;
        acc_fill = 0;
    endfunction

    // A full word is held back until a ninth byte needs the room.
    function automatic void put_coded_byte(logic [7:0] b);
        if (acc_fill >= WORD_BYTES)
            ship_word(1'b0);
        acc_word = acc_word | (64'(b) << (8 * acc_fill));
        acc_fill++;
    endfunction

    function automatic void flush_run();
        int i;
        if (mode == MODE_LIT)
        begin
            put_coded_byte(8'(lit_len - 1));
            for (i = 0; i < lit_len; i++)
                put_coded_byte(lit_bytes[i]);
        end
        else if (mode == MODE_REP)
        begin
            put_coded_byte(8'(257 - rep_len));
            put_coded_byte(rep_byte);
        end
        mode    = MODE_IDLE;
        lit_len = 0;
        rep_len = 0;
    endfunction

    function automatic void grow_literal(logic [7:0] x);
        mode = MODE_LIT;
        lit_bytes[lit_len] = x;
        lit_len++;
        if (lit_len >= MAX_RUN)
            flush_run();
    endfunction

    function automatic void open_repeat(logic [7:0] x);
        mode     = MODE_REP;
        rep_byte = x;
        rep_len  = 1;
        if (rep_len >= MAX_RUN)
            flush_run();
    endfunction

    // Classify byte x, given whichever of the next two bytes are known.
    function automatic void decide_byte(logic [7:0] x, bit has1, logic [7:0] x1,
                                        bit has2, logic [7:0] x2);
        if (mode == MODE_REP)
        begin
            if (x == rep_byte)
            begin
                rep_len++;
                if (rep_len >= MAX_RUN)
                    flush_run();
                return;
            end
            flush_run();
        end
        else if (mode == MODE_LIT)
        begin
            if (!has2 || x != x1 || x != x2)
            begin
                grow_literal(x);
                return;
            end
            flush_run();
        end
        if (has1 && x == x1)
            open_repeat(x);
        else
            grow_literal(x);
    endfunction

    function automatic void clear_stream();
        lit_len    = 0;
        window[0]  = 8'h00;
        window[1]  = 8'h00;
        window_len = 0;
        rep_byte   = 8'h00;
        rep_len    = 0;
        mode       = MODE_IDLE;
        acc_word   = '0;
        acc_fill   = 0;
    endfunction

    function automatic void accept_raw_byte(logic [7:0] b, logic last);
        if (window_len >= 2)
        begin
            decide_byte(window[0], 1'b1, window[1], 1'b1, b);
            window[0] = window[1];
            window[1] = b;
        end
        else
        begin
            window[window_len] = b;
            window_len++;
        end
        if (last)
        begin
            if (window_len >= 2)
            begin
                decide_byte(window[0], 1'b1, window[1], 1'b0, 8'h00);
                decide_byte(window[1], 1'b0, 8'h00, 1'b0, 8'h00);
            end
            else
                decide_byte(window[0], 1'b0, 8'h00, 1'b0, 8'h00);
            flush_run();
            ship_word(1'b1);
            clear_stream();
        end
    endfunction

    function automatic void check_word();
        coded_word_t want;
        if (owed_words.size() == 0)
        begin
            if (mismatches < 10)
                $display("ERROR %0t: word %h count %0d last %b arrived with none owed",
                         $realtime, out_word, out_count, out_last);
            mismatches++;
            return;
        end
        want = owed_words.pop_front();
        if (out_word !== want.word || out_count !== want.count || out_last !== want.last)
        begin
            if (mismatches < 10)
                $display("ERROR %0t: word exp %h got %h, count exp %0d got %0d, last exp %b got %b",
                         $realtime, want.word, out_word, want.count, out_count,
                         want.last, out_last);
            mismatches++;
        end
    endfunction

    // Input transfers are taken before output transfers of the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_stream();
            owed_words.delete();
            mismatches = 0;
            words_owed <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                accept_raw_byte(in_byte, is_last);
            if (out_valid && out_ready)
                check_word();
            words_owed <= owed_words.size();
        end
    end

endmodule

// ===== bench/byte_run_length_encoder_tb.sv =====
`timescale 1ns / 100ps

module byte_run_length_encoder_tb;

    // The slowest legal run is far below this; it only catches a hung block.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Length of the random part, in raw bytes, after the directed streams.
    localparam int RANDOM_ITEMS = 350;
    // Quiet cycles after the last owed word, so that a stray word is still seen.
    localparam int DRAIN_CYCLES = 64;

    typedef enum int {
        SEG_REPEAT,
        SEG_NOISE,
        SEG_ALPHA
    } seg_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = 8'h00;
    logic        is_last   = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_word;
    logic [3:0]  out_count;
    logic        out_last;

    int mismatches;
    int words_owed;
    int cycles     = 0;
    int items_sent = 0;

    // When set, the current stream is sent back to back with no gaps.
    bit calm_in    = 1'b0;
    int stall_left = 0;
    int calm_left  = 0;

    // Raw bytes of the stream that is about to be sent.
    logic [7:0] stream_buf[$];

    byte_run_length_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .out_count (out_count),
        .out_last  (out_last)
    );

    // The checker sits beside the block, follows both channels, and reports
    // its mismatch count and the number of words still owed.
    brle_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .out_count  (out_count),
        .out_last   (out_last),
        .mismatches (mismatches),
        .words_owed (words_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then a long pause.
    // Without allow_zero the result is never zero.
    function automatic int idle_len(bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte and wait for its transfer. A byte that follows without
    // a gap keeps valid high, so valid gets a single assignment per edge.
    task automatic send_byte(logic [7:0] b, logic lst);
        int gap;
        gap = calm_in ? 0 : idle_len(1'b1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Send the buffered stream with the end mark on its final byte.
    task automatic send_stream();
        int i;
        calm_in = ($urandom_range(0, 3) == 0);
        for (i = 0; i < stream_buf.size(); i++)
            send_byte(stream_buf[i], i == stream_buf.size() - 1);
        stream_buf.delete();
    endtask

    // Output side: ready is mostly high, with short and long stalls, and
    // sometimes a long calm stretch with no stall at all.
    always @(posedge clk)
    begin : out_side
        int r;
        if (calm_left > 0)
        begin
            calm_left <= calm_left - 1;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3)
                calm_left <= $urandom_range(50, 200);
            else if (r < 25)
                stall_left <= idle_len(1'b0);
        end
    end

    // Watchdog: a run that never drains ends here as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int         k;
        int         s;
        int         j;
        int         nseg;
        int         seg_len;
        int         r;
        logic [7:0] fill;
        seg_kind_t  kind;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed streams. A lone byte at the bottom of the range.
        stream_buf = '{8'h00};
        send_stream();
        // An equal pair at the top of the range is the shortest repeat run.
        stream_buf = '{8'hFF, 8'hFF};
        send_stream();
        // Two different bytes give a two-byte literal run.
        stream_buf = '{8'h00, 8'hFF};
        send_stream();
        // Three equal bytes, the whole stream one repeat run.
        stream_buf = '{8'hAA, 8'hAA, 8'hAA};
        send_stream();
        // An open literal run takes in a pair among the last two bytes.
        stream_buf = '{8'h01, 8'h02, 8'h03, 8'h03};
        send_stream();
        // A literal run closes just before three equal bytes, then a repeat
        // run, then a lone trailing byte.
        stream_buf = '{8'h01, 8'h02, 8'h07, 8'h07, 8'h07, 8'h80};
        send_stream();
        // A repeat run opens the stream, and the literal run after it takes in
        // the pair at its end.
        stream_buf = '{8'h55, 8'h55, 8'h55, 8'h55, 8'h0F, 8'hF0, 8'hF0};
        send_stream();

        // Random streams built from segments: equal runs, free bytes, and
        // bytes from a three-value alphabet that form pairs and triples often.
        // Two early streams carry runs near the longest run length so that
        // both kinds of run can hit the limit; later this is rare.
        for (k = 0; items_sent < 25 + RANDOM_ITEMS; k++)
        begin
            nseg = $urandom_range(1, 5);
            for (s = 0; s < nseg; s++)
            begin
                r    = $urandom_range(0, 99);
                fill = 8'($urandom_range(0, 255));
                if ((k == 1 && s == 0) || r == 0)
                begin
                    kind    = SEG_REPEAT;
                    seg_len = $urandom_range(127, 131);
                end
                else if ((k == 3 && s == 0) || r == 1)
                begin
                    kind    = SEG_NOISE;
                    seg_len = $urandom_range(126, 130);
                end
                else if (r < 35)
                begin
                    kind    = SEG_REPEAT;
                    seg_len = $urandom_range(1, 5);
                end
                else if (r < 65)
                begin
                    kind    = SEG_NOISE;
                    seg_len = $urandom_range(1, 8);
                end
                else
                begin
                    kind    = SEG_ALPHA;
                    seg_len = $urandom_range(2, 10);
                end
                for (j = 0; j < seg_len; j++)
                begin
                    case (kind)
                        SEG_REPEAT: stream_buf.push_back(fill);
                        SEG_NOISE:  stream_buf.push_back(8'($urandom_range(0, 255)));
                        default:
                        begin
                            r = $urandom_range(0, 2);
                            if (r == 0)
                                stream_buf.push_back(8'h00);
                            else if (r == 1)
                                stream_buf.push_back(8'hFF);
                            else
                                stream_buf.push_back(fill);
                        end
                    endcase
                end
            end
            send_stream();
        end
        in_valid <= 1'b0;

        // The owed count is registered, so step once before
        // looking at it, then let any stray word show up.
        @(posedge clk);
        while (words_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && words_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
